// ===== rtl/core/csr_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_pkg
// Shared constants and the arctangent table for the compass reader.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_pkg;

  localparam int AXIS_BITS_DEF    = 11;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int WAIT_BITS_DEF    = 16;
  localparam int COMMAND_BITS     = 4;

  localparam int OUT_AXIS_BITS = 11;
  localparam int DEG_BITS      = 9;
  localparam int ACC_BITS      = 26;
  localparam int SETTLE_RESET  = 40000;

  localparam logic [3:0] CMD_RESET  = 4'b0000;
  localparam logic [3:0] CMD_START  = 4'b1000;
  localparam logic [3:0] CMD_REPORT = 4'b1100;
  localparam logic [3:0] READY_CODE = 4'd12;

  localparam logic [1:0] REQ_RESET   = 2'd1;
  localparam logic [1:0] REQ_MEASURE = 2'd2;

  function automatic logic [ACC_BITS-1:0] atan_q16(input logic [4:0] i);
    logic [ACC_BITS-1:0] r;
    case (i)
      5'd0: r = 26'd2949120;
      5'd1: r = 26'd1740967;
      5'd2: r = 26'd919879;
      5'd3: r = 26'd466945;
      5'd4: r = 26'd234379;
      5'd5: r = 26'd117304;
      5'd6: r = 26'd58666;
      5'd7: r = 26'd29335;
      5'd8: r = 26'd14668;
      5'd9: r = 26'd7334;
      5'd10: r = 26'd3667;
      5'd11: r = 26'd1833;
      5'd12: r = 26'd917;
      5'd13: r = 26'd458;
      5'd14: r = 26'd229;
      5'd15: r = 26'd115;
      5'd16: r = 26'd57;
      5'd17: r = 26'd29;
      5'd18: r = 26'd14;
      5'd19: r = 26'd7;
      5'd20: r = 26'd4;
      5'd21: r = 26'd2;
      5'd22: r = 26'd1;
      default: r = 26'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csr_cordic.sv =====
// ----------------------------------------------------------------------------
// csr_cordic
// Iterative vectoring CORDIC, one micro-rotation per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_cordic #(
  parameter int AXIS_BITS    = csr_pkg::AXIS_BITS_DEF,
  parameter int CORDIC_STEPS = csr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire  signed [AXIS_BITS-1:0]          x_in,
  input  wire  signed [AXIS_BITS-1:0]          y_in,
  output logic                                 done,
  output logic signed [csr_pkg::DEG_BITS-1:0]  deg
);

  localparam int VW = AXIS_BITS + 12;
  localparam int AW = csr_pkg::ACC_BITS;
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [VW-1:0] px, py;
  logic signed [AW-1:0] acc;
  logic [IW-1:0]        step;
  logic                 run;

  logic signed [VW-1:0] a, b, aa, ab, sx, sy;
  logic signed [AW-1:0] ang, res;
  logic signed [AW-1:0] tr;

  always_comb begin
    a  = -VW'(y_in);
    b  = VW'(x_in);
    aa = a[VW-1] ? -a : a;
    ab = b[VW-1] ? -b : b;
    sx = py >>> step;
    sy = px >>> step;
    ang = AW'(csr_pkg::atan_q16(5'(step)));
    tr = acc[AW-1] ? -((-acc) >>> 16) : (acc >>> 16);
    res = tr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      deg  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        run  <= 1'b1;
        acc  <= '0;
        px   <= b <<< 8;
        py   <= a <<< 8;
        if (a == 0) begin
          run <= 1'b0; done <= 1'b1;
          deg <= b[VW-1] ? 9'sd180 : 9'sd0;
        end else if (b == 0) begin
          run <= 1'b0; done <= 1'b1;
          deg <= a[VW-1] ? -9'sd90 : 9'sd90;
        end else if (aa == ab) begin
          run <= 1'b0; done <= 1'b1;
          if (!b[VW-1]) deg <= a[VW-1] ? -9'sd45 : 9'sd45;
          else deg <= a[VW-1] ? -9'sd135 : 9'sd135;
        end else if (b[VW-1]) begin
          if (!a[VW-1]) begin
            px <= a <<< 8; py <= (-b) <<< 8; acc <= AW'(90 * 65536);
          end else begin
            px <= (-a) <<< 8; py <= b <<< 8; acc <= -AW'(90 * 65536);
          end
        end
      end else if (run) begin
        if (step == IW'(CORDIC_STEPS)) begin
          run  <= 1'b0;
          done <= 1'b1;
          if (res > 180) deg <= 9'sd180;
          else if (res < -180) deg <= -9'sd180;
          else deg <= res[csr_pkg::DEG_BITS-1:0];
        end else begin
          if (!py[VW-1]) begin
            px <= px + sx; py <= py - sy; acc <= acc + ang;
          end else begin
            px <= px - sx; py <= py + sy; acc <= acc - ang;
          end
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/compass_serial_heading_reader.sv =====
// ----------------------------------------------------------------------------
// compass_serial_heading_reader
// Three-wire magnetometer master with iterative CORDIC heading.
// ----------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   one tick word: req_type, data_pin_in
// m_axis    out  pin levels, status and held measurement
// cfg       in   settle_wait_ticks
//
// A plain tick is accepted, then its word is presented. The last axis bit's
// tick runs the CORDIC unit; its word is presented once the CORDIC is done.
// Reset is synchronous and returns to idle with the wait at 40000 ticks.
// A word waiting on m_axis holds s_axis_tready low.
`default_nettype none

module compass_serial_heading_reader #(
  parameter int AXIS_BITS    = csr_pkg::AXIS_BITS_DEF,
  parameter int CORDIC_STEPS = csr_pkg::CORDIC_STEPS_DEF,
  parameter int WAIT_BITS    = csr_pkg::WAIT_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // req_type[1:0], data_pin_in[2], zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,  // clock, enable, data_out, drive, busy,
                                     // valid, found, deg[9], x[11], y[11],
                                     // status[4], zero
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data
);

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_RESET  = 9'b000000010,
    PH_START  = 9'b000000100,
    PH_WAIT   = 9'b000001000,
    PH_REPORT = 9'b000010000,
    PH_STATUS = 9'b000100000,
    PH_RX     = 9'b001000000,
    PH_RY     = 9'b010000000,
    PH_FINISH = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IN   = 3'b001,
    ST_CORD = 3'b010,
    ST_OUT  = 3'b100
  } blk_t;

  localparam int BW = $clog2(AXIS_BITS + 1);
  localparam int OW = csr_pkg::OUT_AXIS_BITS;

  logic [15:0]                 settle;
  phase_t                      phase;
  blk_t                        bst;
  logic [BW-1:0]               bit_index;
  logic                        half_bit;
  logic [WAIT_BITS-1:0]        wait_counter;
  logic [AXIS_BITS-1:0]        shift_word;
  logic signed [AXIS_BITS-1:0] x_value, y_value;
  logic [3:0]                  status_value;
  logic signed [8:0]           angle_value;
  logic                        found_flag;
  logic [5:0]                  pins;

  logic                        cordic_start;
  logic                        cordic_done;
  logic signed [8:0]           cdeg;
  logic [AXIS_BITS-1:0]        ynew;

  assign s_axis_tready = (bst == ST_IN);
  assign m_axis_tvalid = (bst == ST_OUT);
  assign m_axis_tdata = {6'b0, status_value, OW'(y_value), OW'(x_value),
    angle_value, found_flag, pins};
  assign ynew = {shift_word[AXIS_BITS-2:0], s_axis_tdata[2]};

  csr_cordic #(.AXIS_BITS(AXIS_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start),
    .x_in(x_value), .y_in(y_value),
    .done(cordic_done), .deg(cdeg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      settle       <= 16'(csr_pkg::SETTLE_RESET);
      phase        <= PH_IDLE;
      bst          <= ST_IN;
      bit_index    <= '0;
      half_bit     <= 1'b0;
      wait_counter <= '0;
      shift_word   <= '0;
      x_value      <= '0;
      y_value      <= '0;
      status_value <= '0;
      angle_value  <= '0;
      found_flag   <= 1'b0;
      pins         <= 6'b000010;
      cordic_start <= 1'b0;
    end else begin
      cordic_start <= 1'b0;
      if (cfg_wr_en) settle <= cfg_wr_data;
      if (bst == ST_OUT && m_axis_tready) bst <= ST_IN;
      if (bst == ST_CORD && cordic_done) begin
        angle_value <= cdeg;
        found_flag  <= 1'b1;
        bst         <= ST_OUT;
      end
      if (s_axis_tvalid && s_axis_tready) begin : tick
        phase_t        ph;
        logic [3:0]    cmd;
        logic [BW-1:0] bi;
        logic [AXIS_BITS-1:0] sw;
        ph = phase;
        cmd = shift_word[3:0];
        bi = bit_index;
        bst <= ST_OUT;
        if (phase == PH_IDLE) begin
          if (s_axis_tdata[1:0] == csr_pkg::REQ_RESET) begin
            ph = PH_RESET; cmd = csr_pkg::CMD_RESET;
            bi = BW'(csr_pkg::COMMAND_BITS);
          end else if (s_axis_tdata[1:0] == csr_pkg::REQ_MEASURE) begin
            ph = PH_START; cmd = csr_pkg::CMD_START;
            bi = BW'(csr_pkg::COMMAND_BITS);
          end
        end
        sw = AXIS_BITS'({shift_word[AXIS_BITS-1:1], 1'b0} | AXIS_BITS'(cmd));
        if (ph == PH_RESET || ph == PH_START) sw = AXIS_BITS'(cmd);
        case (ph)
          PH_RESET, PH_START, PH_REPORT: begin
            pins <= {1'b0, 1'b1, 1'b1, cmd[2'(bi - 1'b1)], 1'b0, half_bit};
            phase <= ph;
            shift_word <= sw;
            bit_index <= bi;
            if (!half_bit) begin
              half_bit <= 1'b1;
            end else begin
              half_bit <= 1'b0;
              bit_index <= bi - 1'b1;
              if (bi == BW'(1)) begin
                if (ph == PH_RESET) begin
                  phase <= PH_IDLE;
                end else if (ph == PH_START) begin
                  if (WAIT_BITS'(settle) == '0) begin
                    phase <= PH_REPORT;
                    shift_word <= AXIS_BITS'(csr_pkg::CMD_REPORT);
                    bit_index <= BW'(csr_pkg::COMMAND_BITS);
                  end else begin
                    phase <= PH_WAIT;
                    wait_counter <= WAIT_BITS'(settle);
                  end
                end else begin
                  phase <= PH_STATUS;
                  shift_word <= '0;
                  bit_index <= BW'(4);
                end
              end
            end
          end
          PH_WAIT: begin
            pins <= 6'b011010;
            wait_counter <= wait_counter - 1'b1;
            if (wait_counter == WAIT_BITS'(1)) begin
              phase <= PH_REPORT;
              shift_word <= AXIS_BITS'(csr_pkg::CMD_REPORT);
              bit_index <= BW'(csr_pkg::COMMAND_BITS);
              half_bit <= 1'b0;
            end
          end
          PH_STATUS, PH_RX, PH_RY: begin
            pins <= {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ~half_bit};
            if (!half_bit) begin
              half_bit <= 1'b1;
            end else begin
              half_bit <= 1'b0;
              shift_word <= ynew;
              bit_index <= bit_index - 1'b1;
              if (bit_index == BW'(1)) begin
                shift_word <= '0;
                bit_index <= BW'(AXIS_BITS);
                if (phase == PH_STATUS) begin
                  status_value <= ynew[3:0];
                  if (ynew[3:0] == csr_pkg::READY_CODE) begin
                    phase <= PH_RX;
                  end else begin
                    found_flag <= 1'b0; x_value <= '0; y_value <= '0;
                    angle_value <= '0;
                    phase <= PH_FINISH;
                  end
                end else if (phase == PH_RX) begin
                  x_value <= ynew;
                  phase <= PH_RY;
                end else begin
                  y_value <= ynew;
                  phase <= PH_FINISH;
                  cordic_start <= 1'b1;
                  bst <= ST_CORD;
                end
              end
            end
          end
          PH_FINISH: begin
            pins <= 6'b110010;
            phase <= PH_IDLE;
          end
          default: begin
            pins <= 6'b000010;
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/csr_checker.sv =====
// ----------------------------------------------------------------------------
// csr_checker
// Port-level checks for the compass reader.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata
);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while word pending");

  a_word_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted twice");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled word changed");

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[4])
    else $error("result without busy");

endmodule

bind compass_serial_heading_reader csr_checker u_csr_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

// ===== verif/tb_compass_serial_heading_reader.sv =====
// ----------------------------------------------------------------------------
// tb_compass_serial_heading_reader
// Drives tick words into the compass reader: reset commands, measurement
// sequences with chosen status and axis bits, broken sequences and noise.
// It predicts each output word and checks it field by field under random
// stalls on both sides and several settle wait settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_compass_serial_heading_reader;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_SEND_RESET, SEQ_SEND_START, SEQ_WAIT, SEQ_SEND_REPORT,
    SEQ_READ_STATUS, SEQ_READ_X, SEQ_READ_Y, SEQ_FINISH
  } seq_phase_t;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [5:0]  pad;
    logic [3:0]  status;
    logic [10:0] y;
    logic [10:0] x;
    logic [8:0]  deg;
    logic        found;
    logic        valid;
    logic        busy;
    logic        drive;
    logic        dout;
    logic        enable;
    logic        sclk;
  } pin_word_t;

  typedef struct packed {
    logic       pin;
    logic [1:0] req;
  } tick_t;

  localparam longint ATAN_Q16[16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  tick_t     pending_ticks[$];
  pin_word_t expected_words[$];
  int        mismatches = 0;
  int        sender_idle_pct = 34;
  int        receiver_idle_pct = 69;

  // Predicted block state.
  logic [15:0] settle_ticks;
  seq_phase_t  seq_phase;
  logic [4:0]  bits_left;
  logic        second_half;
  logic [15:0] wait_left;
  logic [10:0] shifter;
  logic [10:0] x_hold, y_hold;
  logic [3:0]  status_hold;
  logic [8:0]  deg_hold;
  logic        found_hold;

  compass_serial_heading_reader u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int heading_deg(int xs, int ys);
    longint a, b, px, py, acc, dx, dy, t, deg;
    a = -longint'(ys);
    b = xs;
    acc = 0;
    if (a == 0) return (b < 0) ? 180 : 0;
    if (b == 0) return (a > 0) ? 90 : -90;
    if ((a < 0 ? -a : a) == (b < 0 ? -b : b)) begin
      if (b > 0) return (a > 0) ? 45 : -45;
      return (a > 0) ? 135 : -135;
    end
    px = b * 256;
    py = a * 256;
    if (b < 0) begin
      t = px;
      if (py >= 0) begin
        px = py; py = -t; acc = 90 * 65536;
      end else begin
        px = -py; py = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py >= 0) begin
        px += dx; py -= dy; acc += ATAN_Q16[i];
      end else begin
        px -= dx; py += dy; acc -= ATAN_Q16[i];
      end
    end
    deg = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
    if (deg > 180) deg = 180;
    if (deg < -180) deg = -180;
    return int'(deg);
  endfunction

  function automatic void start_command(seq_phase_t ph, logic [3:0] cmd);
    seq_phase = ph;
    shifter = {7'd0, cmd};
    bits_left = 5'(csr_pkg::COMMAND_BITS);
    second_half = 1'b0;
  endfunction

  function automatic void start_read(seq_phase_t ph, int nbits);
    seq_phase = ph;
    shifter = '0;
    bits_left = 5'(nbits);
    second_half = 1'b0;
  endfunction

  function automatic void clear_prediction();
    settle_ticks = 16'(csr_pkg::SETTLE_RESET);
    seq_phase = SEQ_IDLE;
    bits_left = '0;
    second_half = 1'b0;
    wait_left = '0;
    shifter = '0;
    x_hold = '0;
    y_hold = '0;
    status_hold = '0;
    deg_hold = '0;
    found_hold = 1'b0;
  endfunction

  function automatic pin_word_t predict_tick(tick_t tk);
    pin_word_t w;
    logic [4:0] sel;
    w = '0;
    w.enable = 1'b1;
    if (seq_phase == SEQ_IDLE) begin
      if (tk.req == csr_pkg::REQ_RESET)
        start_command(SEQ_SEND_RESET, csr_pkg::CMD_RESET);
      else if (tk.req == csr_pkg::REQ_MEASURE)
        start_command(SEQ_SEND_START, csr_pkg::CMD_START);
    end
    case (seq_phase)
      SEQ_SEND_RESET, SEQ_SEND_START, SEQ_SEND_REPORT: begin
        w.enable = 1'b0; w.drive = 1'b1; w.busy = 1'b1;
        sel = bits_left - 5'd1;
        w.dout = shifter[sel[1:0]];
        w.sclk = second_half;
        if (!second_half) begin
          second_half = 1'b1;
        end else begin
          second_half = 1'b0;
          if (bits_left > 0) bits_left--;
          if (bits_left == 0) begin
            if (seq_phase == SEQ_SEND_RESET) begin
              seq_phase = SEQ_IDLE;
            end else if (seq_phase == SEQ_SEND_START) begin
              if (settle_ticks == 0) begin
                start_command(SEQ_SEND_REPORT, csr_pkg::CMD_REPORT);
              end else begin
                seq_phase = SEQ_WAIT;
                wait_left = settle_ticks;
              end
            end else begin
              start_read(SEQ_READ_STATUS, 4);
            end
          end
        end
      end
      SEQ_WAIT: begin
        w.drive = 1'b1; w.busy = 1'b1;
        if (wait_left > 0) wait_left--;
        if (wait_left == 0) start_command(SEQ_SEND_REPORT, csr_pkg::CMD_REPORT);
      end
      SEQ_READ_STATUS, SEQ_READ_X, SEQ_READ_Y: begin
        w.enable = 1'b0; w.busy = 1'b1;
        if (!second_half) begin
          w.sclk = 1'b1;
          second_half = 1'b1;
        end else begin
          second_half = 1'b0;
          shifter = {shifter[9:0], tk.pin};
          if (bits_left > 0) bits_left--;
          if (bits_left == 0) begin
            if (seq_phase == SEQ_READ_STATUS) begin
              status_hold = shifter[3:0];
              if (status_hold == csr_pkg::READY_CODE) begin
                start_read(SEQ_READ_X, 11);
              end else begin
                found_hold = 1'b0; x_hold = '0; y_hold = '0; deg_hold = '0;
                seq_phase = SEQ_FINISH;
              end
            end else if (seq_phase == SEQ_READ_X) begin
              x_hold = shifter;
              start_read(SEQ_READ_Y, 11);
            end else begin
              y_hold = shifter;
              deg_hold = 9'(heading_deg($signed(x_hold), $signed(y_hold)));
              found_hold = 1'b1;
              seq_phase = SEQ_FINISH;
            end
          end
        end
      end
      SEQ_FINISH: begin
        w.busy = 1'b1; w.valid = 1'b1;
        seq_phase = SEQ_IDLE;
      end
      default: seq_phase = SEQ_IDLE;
    endcase
    w.found = found_hold;
    w.deg = deg_hold;
    w.x = x_hold;
    w.y = y_hold;
    w.status = status_hold;
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic push_tick(logic [1:0] req, logic pin);
    tick_t tk;
    tk.req = req;
    tk.pin = pin;
    pending_ticks.push_back(tk);
  endtask

  // Requests on ticks inside a sequence are ignored, so they carry noise.
  task automatic filler_tick();
    push_tick(2'($urandom_range(0, 3)), 1'($urandom));
  endtask

  task automatic read_bits(logic [10:0] v, int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      filler_tick();
      push_tick(2'($urandom_range(0, 3)), v[i]);
    end
  endtask

  task automatic queue_measurement(int settle, logic [3:0] status,
                                   logic [10:0] xv, logic [10:0] yv);
    push_tick(csr_pkg::REQ_MEASURE, 1'($urandom));
    repeat (7 + settle + 8) filler_tick();
    read_bits({7'd0, status}, 4);
    if (status == csr_pkg::READY_CODE) begin
      read_bits(xv, 11);
      read_bits(yv, 11);
    end
    filler_tick();
  endtask

  task automatic queue_reset_command();
    push_tick(csr_pkg::REQ_RESET, 1'($urandom));
    repeat (7) filler_tick();
  endtask

  function automatic logic [10:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 11'h400;
      1: return 11'h3ff;
      2: return 11'($urandom_range(0, 3));
      default: return 11'($urandom);
    endcase
  endfunction

  task automatic queue_random_work(int settle, int ticks);
    int start;
    int pick;
    start = pending_ticks.size();
    while (pending_ticks.size() - start < ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        queue_measurement(settle, csr_pkg::READY_CODE, random_axis(), random_axis());
      end else if (pick < 75) begin
        queue_measurement(settle, 4'($urandom), random_axis(), random_axis());
      end else if (pick < 85) begin
        queue_reset_command();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) push_tick(REQ_TICK, 1'($urandom));
      end else begin
        // A sequence cut short: the block must stay in step with its own count.
        push_tick(2'($urandom_range(1, 3)), 1'($urandom));
        repeat ($urandom_range(0, 20)) filler_tick();
      end
    end
  endtask

  task automatic drain_to_idle();
    do begin
      while (pending_ticks.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
        @(posedge clk);
      if (seq_phase != SEQ_IDLE) push_tick(REQ_TICK, 1'b0);
    end while (seq_phase != SEQ_IDLE || pending_ticks.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_settle(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    settle_ticks = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    tick_t tk;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(predict_tick(tick_t'(s_axis_tdata[2:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          tk = pending_ticks.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'd0, tk.pin, tk.req};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pin_word_t got, want;
    if (!rst) begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = pin_word_t'(m_axis_tdata);
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.sclk !== want.sclk) report_mismatch("clock", got.sclk, want.sclk);
          if (got.enable !== want.enable) report_mismatch("enable", got.enable, want.enable);
          if (got.dout !== want.dout) report_mismatch("data_out", got.dout, want.dout);
          if (got.drive !== want.drive) report_mismatch("drive", got.drive, want.drive);
          if (got.busy !== want.busy) report_mismatch("busy", got.busy, want.busy);
          if (got.valid !== want.valid) report_mismatch("valid", got.valid, want.valid);
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.deg !== want.deg)
            report_mismatch("heading", $signed(got.deg), $signed(want.deg));
          if (got.x !== want.x) report_mismatch("raw_x", $signed(got.x), $signed(want.x));
          if (got.y !== want.y) report_mismatch("raw_y", $signed(got.y), $signed(want.y));
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.pad !== want.pad) report_mismatch("pad", got.pad, want.pad);
        end
      end
    end
  end

  initial begin
    int settle_plan[6] = '{3, 1, 7, 2, 40, 5};
    clear_prediction();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with no wait between start and report.
    write_settle(16'd0);
    queue_reset_command();
    queue_measurement(0, 4'd3, '0, '0);
    queue_measurement(0, 4'd15, '0, '0);
    queue_measurement(0, 4'd0, '0, '0);
    queue_measurement(0, csr_pkg::READY_CODE, 11'd0, 11'd0);
    queue_measurement(0, csr_pkg::READY_CODE, 11'h3ff, 11'd0);
    queue_measurement(0, csr_pkg::READY_CODE, 11'h400, 11'd0);
    queue_measurement(0, csr_pkg::READY_CODE, 11'd0, 11'h3ff);
    queue_measurement(0, csr_pkg::READY_CODE, 11'd0, 11'h400);
    queue_measurement(0, csr_pkg::READY_CODE, 11'd37, 11'd37);
    queue_measurement(0, csr_pkg::READY_CODE, 11'd37, -11'sd37);
    queue_measurement(0, csr_pkg::READY_CODE, -11'sd37, 11'd37);
    queue_measurement(0, csr_pkg::READY_CODE, 11'h400, 11'h400);
    queue_measurement(0, csr_pkg::READY_CODE, 11'h400, 11'h3ff);
    queue_measurement(0, csr_pkg::READY_CODE, -11'sd500, -11'sd3);
    queue_measurement(0, csr_pkg::READY_CODE, 11'h7ff, 11'd2);
    push_tick(REQ_SPARE, 1'b1);
    push_tick(REQ_TICK, 1'b1);
    drain_to_idle();

    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = (p < 2) ? 34 : (p < 4) ? 69 : 0;
      receiver_idle_pct = (p < 2) ? 69 : (p < 4) ? 34 : 0;
      write_settle(16'(settle_plan[p]));
      queue_random_work(settle_plan[p], 180);
      drain_to_idle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== compass_serial_heading_reader.f =====
rtl/core/csr_pkg.sv
rtl/core/csr_cordic.sv
rtl/core/compass_serial_heading_reader.sv
rtl/core/csr_checker.sv
verif/tb_compass_serial_heading_reader.sv
